FILE: rtl/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg
// Types, constants and helpers shared by the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

    typedef logic signed [63:0] sig64_t;
    typedef logic signed [35:0] coef_t;
    typedef logic signed [19:0] coef20_t;
    typedef logic signed [23:0] raw_s_t;
    typedef logic signed [15:0] temp_t;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [31:0] pressure;
    } result_t;

    typedef struct packed {
        coef20_t a0;
        coef20_t b00;
        coef_t   a1;
        coef_t   a2;
        coef_t   bt1;
        coef_t   bt2;
        coef_t   bp1;
        coef_t   b11;
        coef_t   bp2;
        coef_t   b12;
        coef_t   b21;
        coef_t   bp3;
    } coef_set_t;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_LO   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_MID  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_HI   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_LAST = 8'd3;

    localparam coef_t K_A1    = 36'sd3608;
    localparam coef_t OFF_A1  = -36'sd1731677965;
    localparam coef_t K_A2    = 36'sd16889;
    localparam coef_t OFF_A2  = -36'sd87619360;
    localparam coef_t K_BT1   = 36'sd2982;
    localparam coef_t OFF_BT1 = 36'sd107370906;
    localparam coef_t K_BT2   = 36'sd329854;
    localparam coef_t OFF_BT2 = 36'sd108083093;
    localparam coef_t K_BP1   = 36'sd19923;
    localparam coef_t OFF_BP1 = 36'sd1133836764;
    localparam coef_t K_B11   = 36'sd2406;
    localparam coef_t OFF_B11 = 36'sd118215883;
    localparam coef_t K_BP2   = 36'sd3079;
    localparam coef_t OFF_BP2 = -36'sd181579595;
    localparam coef_t K_B12   = 36'sd6846;
    localparam coef_t OFF_B12 = 36'sd85590281;
    localparam coef_t K_B21   = 36'sd13836;
    localparam coef_t OFF_B21 = 36'sd79333336;
    localparam coef_t K_BP3   = 36'sd2915;
    localparam coef_t OFF_BP3 = 36'sd157155561;

    localparam int DIV_SHIFT   = 15;
    localparam int DIVISOR     = 32767;
    localparam int DIV_REM_W   = 18;
    localparam int DIV_FIX_MAX = 5;

    localparam int TEMP_DEPTH  = 7;
    localparam int PRESS_DEPTH = 9;
    localparam int PIPE_DEPTH  = TEMP_DEPTH + PRESS_DEPTH;

    function automatic coef_t scale16(input logic [15:0] c, input coef_t k, input coef_t off);
        coef_t ce;
        ce = coef_t'($signed(c));
        return ce * k + off;
    endfunction

    function automatic raw_s_t center_raw(input logic [23:0] r);
        return $signed({~r[23], r[22:0]});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Temperature and pressure each pass through their own three-stage divide-by-32767 unit.
// Reset clears the calibration registers and all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Pipelined integer temperature and pressure compensation of raw sensor codes.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire btpc_pkg::sample_t                   sample,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output btpc_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [btpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [63:0]                         cfg_data
);

    btpc_pkg::coef_set_t coef;
    btpc_pkg::temp_t     temp;
    logic [23:0]         rp_dly;
    logic signed [31:0]  pressure;
    logic                en;
    logic [btpc_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [btpc_pkg::PIPE_DEPTH-1:0] vld_next;
    btpc_pkg::temp_t t_dly_reg [btpc_pkg::PRESS_DEPTH];

    assign cfg_ready    = 1'b1;
    assign en           = !vld_reg[btpc_pkg::PIPE_DEPTH-1] || result_ready;
    assign sample_ready = en;
    assign vld_next     = {vld_reg[btpc_pkg::PIPE_DEPTH-2:0], sample_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    btpc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    btpc_temp u_temp (
        .clk              (clk),
        .en               (en),
        .coef             (coef),
        .raw_temperature  (sample.raw_temperature),
        .raw_pressure     (sample.raw_pressure),
        .temp             (temp),
        .raw_pressure_dly (rp_dly)
    );

    btpc_press u_press (
        .clk          (clk),
        .en           (en),
        .coef         (coef),
        .temp         (temp),
        .raw_pressure (rp_dly),
        .pressure     (pressure)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_dly_reg[0] <= temp;
            for (int i = 1; i < btpc_pkg::PRESS_DEPTH; i++)
                t_dly_reg[i] <= t_dly_reg[i-1];
        end
    end

    assign result_valid       = vld_reg[btpc_pkg::PIPE_DEPTH-1];
    assign result.temperature = t_dly_reg[btpc_pkg::PRESS_DEPTH-1];
    assign result.pressure    = pressure;

`ifndef NO_ASSERTIONS
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (result_valid && !result_ready))
        else $error("pipeline held without a blocked result");

    a_entry_tracks_input: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (vld_reg[0] == $past(sample_valid)))
        else $error("entry valid bit lost an accepted word");

    a_hold_valid_bits: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a hold");
`endif

endmodule
`default_nettype wire

FILE: rtl/btpc_coef.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_coef
// Calibration registers and registered derivation of the scaled coefficients.
// ----------------------------------------------------------------------------
module btpc_coef (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [btpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [63:0]                         cfg_data,
    output btpc_pkg::coef_set_t                      coef
);

    logic [63:0] cal_lo_reg;
    logic [63:0] cal_mid_reg;
    logic [63:0] cal_hi_reg;
    logic [7:0]  cal_last_reg;
    btpc_pkg::coef_set_t coef_reg;
    btpc_pkg::coef_set_t coef_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_lo_reg   <= '0;
            cal_mid_reg  <= '0;
            cal_hi_reg   <= '0;
            cal_last_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                btpc_pkg::CFG_CAL_LO:   cal_lo_reg   <= cfg_data;
                btpc_pkg::CFG_CAL_MID:  cal_mid_reg  <= cfg_data;
                btpc_pkg::CFG_CAL_HI:   cal_hi_reg   <= cfg_data;
                btpc_pkg::CFG_CAL_LAST: cal_last_reg <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        coef_next.a0  = $signed({cal_hi_reg[47:32], cal_last_reg[3:0]});
        coef_next.b00 = $signed({cal_lo_reg[63:48], cal_last_reg[7:4]});
        coef_next.a1  = btpc_pkg::scale16(cal_hi_reg[31:16], btpc_pkg::K_A1, btpc_pkg::OFF_A1);
        coef_next.a2  = btpc_pkg::scale16(cal_hi_reg[15:0], btpc_pkg::K_A2, btpc_pkg::OFF_A2);
        coef_next.bt1 = btpc_pkg::scale16(cal_lo_reg[47:32], btpc_pkg::K_BT1, btpc_pkg::OFF_BT1);
        coef_next.bt2 = btpc_pkg::scale16(cal_lo_reg[31:16], btpc_pkg::K_BT2, btpc_pkg::OFF_BT2);
        coef_next.bp1 = btpc_pkg::scale16(cal_lo_reg[15:0], btpc_pkg::K_BP1, btpc_pkg::OFF_BP1);
        coef_next.b11 = btpc_pkg::scale16(cal_mid_reg[63:48], btpc_pkg::K_B11, btpc_pkg::OFF_B11);
        coef_next.bp2 = btpc_pkg::scale16(cal_mid_reg[47:32], btpc_pkg::K_BP2, btpc_pkg::OFF_BP2);
        coef_next.b12 = btpc_pkg::scale16(cal_mid_reg[31:16], btpc_pkg::K_B12, btpc_pkg::OFF_B12);
        coef_next.b21 = btpc_pkg::scale16(cal_mid_reg[15:0], btpc_pkg::K_B21, btpc_pkg::OFF_B21);
        coef_next.bp3 = btpc_pkg::scale16(cal_hi_reg[63:48], btpc_pkg::K_BP3, btpc_pkg::OFF_BP3);
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

FILE: rtl/btpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_div
// Three-stage signed division by 32767, truncating toward zero.
// ----------------------------------------------------------------------------
module btpc_div (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire btpc_pkg::sig64_t x,
    output btpc_pkg::sig64_t     q
);

    logic [63:0] mag_next;
    logic [63:0] est_next;
    logic [63:0] est1_reg;
    logic        neg1_reg;
    logic [63:0] mag1_reg;
    logic [63:0] rem_full;
    logic [63:0] est2_reg;
    logic [btpc_pkg::DIV_REM_W-1:0] rem2_reg;
    logic        neg2_reg;
    logic [2:0]  fix;
    logic [63:0] quo;
    btpc_pkg::sig64_t q_reg;
    btpc_pkg::sig64_t q_next;

    always_comb
    begin
        mag_next = x[63] ? 64'(-x) : 64'(x);
        est_next = (mag_next >> btpc_pkg::DIV_SHIFT) + (mag_next >> (2 * btpc_pkg::DIV_SHIFT))
                 + (mag_next >> (3 * btpc_pkg::DIV_SHIFT))
                 + (mag_next >> (4 * btpc_pkg::DIV_SHIFT));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag_next;
            est1_reg <= est_next;
            neg1_reg <= x[63];
        end
    end

    assign rem_full = mag1_reg - (est1_reg << btpc_pkg::DIV_SHIFT) + est1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est2_reg <= est1_reg;
            rem2_reg <= rem_full[btpc_pkg::DIV_REM_W-1:0];
            neg2_reg <= neg1_reg;
        end
    end

    always_comb
    begin
        fix = '0;
        for (int k = 1; k <= btpc_pkg::DIV_FIX_MAX; k++)
        begin
            if (rem2_reg >= btpc_pkg::DIV_REM_W'(k * btpc_pkg::DIVISOR))
                fix = fix + 3'd1;
        end
        quo    = est2_reg + 64'(fix);
        q_next = neg2_reg ? -$signed(quo) : $signed(quo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

FILE: rtl/btpc_temp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_temp
// Temperature polynomial: seven stages, raw pressure carried alongside.
// ----------------------------------------------------------------------------
module btpc_temp (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire btpc_pkg::coef_set_t coef,
    input  wire logic [23:0]         raw_temperature,
    input  wire logic [23:0]         raw_pressure,
    output btpc_pkg::temp_t          temp,
    output logic [23:0]              raw_pressure_dly
);

    btpc_pkg::raw_s_t rt;
    btpc_pkg::raw_s_t rt1_reg;
    btpc_pkg::sig64_t p1_reg;
    btpc_pkg::sig64_t p2_reg;
    btpc_pkg::sig64_t p1b_reg;
    btpc_pkg::sig64_t u_reg;
    btpc_pkg::sig64_t s_reg;
    btpc_pkg::sig64_t p2s;
    btpc_pkg::sig64_t q;
    btpc_pkg::sig64_t tw;
    btpc_pkg::temp_t  t_reg;
    logic [23:0] rp_reg [btpc_pkg::TEMP_DEPTH];

    assign rt  = btpc_pkg::center_raw(raw_temperature);
    assign p2s = p2_reg >>> 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= coef.a1 * rt;
            p2_reg  <= coef.a2 * rt;
            rt1_reg <= rt;
            p1b_reg <= p1_reg;
            u_reg   <= $signed(p2s[49:0]) * rt1_reg;
            s_reg   <= p1b_reg + (u_reg >>> 10);
            t_reg   <= tw[19:4];
            rp_reg[0] <= raw_pressure;
            for (int i = 1; i < btpc_pkg::TEMP_DEPTH; i++)
                rp_reg[i] <= rp_reg[i-1];
        end
    end

    btpc_div u_div (
        .clk (clk),
        .en  (en),
        .x   (s_reg),
        .q   (q)
    );

    assign tw = btpc_pkg::sig64_t'(coef.a0) + (q >>> 19);

    assign temp             = t_reg;
    assign raw_pressure_dly = rp_reg[btpc_pkg::TEMP_DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/btpc_press.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_press
// Pressure polynomial: nine stages fed with the compensated temperature.
// ----------------------------------------------------------------------------
module btpc_press (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire btpc_pkg::coef_set_t coef,
    input  wire btpc_pkg::temp_t     temp,
    input  wire logic [23:0]         raw_pressure,
    output logic signed [31:0]       pressure
);

    btpc_pkg::raw_s_t rp;
    btpc_pkg::raw_s_t rp1_reg;
    btpc_pkg::raw_s_t rp2_reg;
    btpc_pkg::temp_t  t1_reg;
    btpc_pkg::sig64_t m_bt1_reg, m_bp1_reg, m_bt2_reg, m_b11_reg;
    btpc_pkg::sig64_t m_bp2_reg, m_b12_reg, m_b21_reg, m_bp3_reg;
    btpc_pkg::sig64_t sh_bt2, sh_b11, sh_bp2, sh_b21, sh_bp3;
    btpc_pkg::sig64_t w1a2_reg, x2_reg, y2_reg, z2_reg, v2_reg, g2_reg, h2_reg;
    btpc_pkg::sig64_t sh_v2, sh_g2, sh_h2;
    btpc_pkg::sig64_t w1a3_reg, w3a3_reg, v3_reg, g3_reg, h3_reg;
    btpc_pkg::sig64_t w1a4_reg, w3a4_reg, w3b4_reg;
    btpc_pkg::sig64_t w1b_reg;
    btpc_pkg::sig64_t q;
    btpc_pkg::sig64_t p_full;
    logic signed [31:0] p_reg;

    assign rp = btpc_pkg::center_raw(raw_pressure);

    always_comb
    begin
        sh_bt2 = m_bt2_reg >>> 1;
        sh_b11 = m_b11_reg >>> 4;
        sh_bp2 = m_bp2_reg >>> 13;
        sh_b21 = m_b21_reg >>> 6;
        sh_bp3 = m_bp3_reg >>> 12;
        sh_v2  = v2_reg >>> 22;
        sh_g2  = g2_reg >>> 23;
        sh_h2  = h2_reg >>> 23;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= temp;
            rp1_reg   <= rp;
            m_bt1_reg <= coef.bt1 * temp;
            m_bp1_reg <= coef.bp1 * rp;
            m_bt2_reg <= coef.bt2 * temp;
            m_b11_reg <= coef.b11 * temp;
            m_bp2_reg <= coef.bp2 * rp;
            m_b12_reg <= coef.b12 * temp;
            m_b21_reg <= coef.b21 * temp;
            m_bp3_reg <= coef.bp3 * rp;

            rp2_reg  <= rp1_reg;
            w1a2_reg <= m_bt1_reg + (m_bp1_reg >>> 5);
            x2_reg   <= $signed(sh_bt2[49:0]) * t1_reg;
            y2_reg   <= $signed(sh_b11[49:0]) * rp1_reg;
            z2_reg   <= $signed(sh_bp2[49:0]) * rp1_reg;
            v2_reg   <= $signed(m_b12_reg[49:0]) * t1_reg;
            g2_reg   <= $signed(sh_b21[49:0]) * rp1_reg;
            h2_reg   <= $signed(sh_bp3[49:0]) * rp1_reg;

            w1a3_reg <= w1a2_reg;
            w3a3_reg <= (x2_reg >>> 8) + (y2_reg >>> 1) + (z2_reg >>> 1);
            v3_reg   <= $signed(sh_v2[49:0]) * rp2_reg;
            g3_reg   <= $signed(sh_g2[49:0]) * rp2_reg;
            h3_reg   <= $signed(sh_h2[49:0]) * rp2_reg;

            w1a4_reg <= w1a3_reg;
            w3a4_reg <= w3a3_reg;
            w3b4_reg <= (v3_reg >>> 1) + (g3_reg >>> 1) + h3_reg;

            w1b_reg  <= w1a4_reg + (w3a4_reg >>> 14) + (w3b4_reg >>> 15);

            p_reg    <= p_full[31:0];
        end
    end

    btpc_div u_div (
        .clk (clk),
        .en  (en),
        .x   (w1b_reg),
        .q   (q)
    );

    assign p_full   = (q >>> 11) + btpc_pkg::sig64_t'(coef.b00);
    assign pressure = p_reg;

endmodule
`default_nettype wire
